[sv/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[sv/ssst_pkg.sv]
package ssst_pkg;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 36;   // rounded Q3.28 x Q15.16 product, Q19.16
    localparam int SUM_W     = 38;   // three rounded products added exactly
    localparam int RND_SHIFT = 28;
    localparam int CFG_IDX_W = 4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_A11 = 4'd0;
    localparam t_cfg_idx REG_A12 = 4'd1;
    localparam t_cfg_idx REG_A21 = 4'd2;
    localparam t_cfg_idx REG_A22 = 4'd3;
    localparam t_cfg_idx REG_B1  = 4'd4;
    localparam t_cfg_idx REG_B2  = 4'd5;
    localparam t_cfg_idx REG_C1  = 4'd6;
    localparam t_cfg_idx REG_C2  = 4'd7;

    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [DATA_W-1:0] RST_A11 = 32'd268435456;
    localparam logic [DATA_W-1:0] RST_A12 = 32'd2684355;
    localparam logic [DATA_W-1:0] RST_A21 = 32'd0;
    localparam logic [DATA_W-1:0] RST_A22 = 32'd268435456;
    localparam logic [DATA_W-1:0] RST_B1  = 32'd13422;
    localparam logic [DATA_W-1:0] RST_B2  = 32'd2684355;
    localparam logic [DATA_W-1:0] RST_C1  = 32'd268435456;
    localparam logic [DATA_W-1:0] RST_C2  = 32'd0;

    localparam logic [DATA_W-1:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [DATA_W-1:0] a11;
        logic [DATA_W-1:0] a12;
        logic [DATA_W-1:0] a21;
        logic [DATA_W-1:0] a22;
        logic [DATA_W-1:0] b1;
        logic [DATA_W-1:0] b2;
        logic [DATA_W-1:0] c1;
        logic [DATA_W-1:0] c2;
    } t_coefs;

    typedef struct packed {
        logic              clip;
        logic [DATA_W-1:0] val;
    } t_sat;

    // Q3.28 x Q15.16, round half up back to Q15.16, kept at full width
    function automatic logic signed [PROD_W-1:0] mul_round(
        input logic [DATA_W-1:0] coef,
        input logic [DATA_W-1:0] val
    );
        logic signed [2*DATA_W-1:0] p;
        logic signed [2*DATA_W-1:0] r;
        p = $signed(coef) * $signed(val);
        r = (p + (64'sd1 <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
        return r[PROD_W-1:0];
    endfunction

    // clip to signed 32 bits; out of range when bits 31 and up do not all agree
    function automatic t_sat sat32(input logic signed [SUM_W-1:0] s);
        t_sat res;
        res.clip = !((&s[SUM_W-1:DATA_W-1]) || !(|s[SUM_W-1:DATA_W-1]));
        if (res.clip) begin
            res.val = s[SUM_W-1] ? Q_MIN : Q_MAX;
        end else begin
            res.val = s[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

[sv/ssst_core.sv]
module ssst_core
    import ssst_pkg::*;
(
    input  t_coefs            i_coefs,
    input  logic [DATA_W-1:0] i_state_one,
    input  logic [DATA_W-1:0] i_state_two,
    input  logic              i_command,
    input  logic [DATA_W-1:0] i_u_sample,
    input  logic [DATA_W-1:0] i_load_one,
    input  logic [DATA_W-1:0] i_load_two,
    output logic [DATA_W-1:0] o_y,
    output logic [DATA_W-1:0] o_state_one,
    output logic [DATA_W-1:0] o_state_two,
    output logic              o_sat
);

    logic signed [PROD_W-1:0] c1x1, c2x2, a11x1, a12x2, b1u, a21x1, a22x2, b2u;
    logic signed [SUM_W-1:0]  sum_y, sum_one, sum_two;
    t_sat                     sat_y, sat_one, sat_two;

    // eight products in parallel, all from the state before this request
    assign c1x1  = mul_round(i_coefs.c1,  i_state_one);
    assign c2x2  = mul_round(i_coefs.c2,  i_state_two);
    assign a11x1 = mul_round(i_coefs.a11, i_state_one);
    assign a12x2 = mul_round(i_coefs.a12, i_state_two);
    assign b1u   = mul_round(i_coefs.b1,  i_u_sample);
    assign a21x1 = mul_round(i_coefs.a21, i_state_one);
    assign a22x2 = mul_round(i_coefs.a22, i_state_two);
    assign b2u   = mul_round(i_coefs.b2,  i_u_sample);

    assign sum_y   = SUM_W'(c1x1) + SUM_W'(c2x2);
    assign sum_one = SUM_W'(a11x1) + SUM_W'(a12x2) + SUM_W'(b1u);
    assign sum_two = SUM_W'(a21x1) + SUM_W'(a22x2) + SUM_W'(b2u);

    assign sat_y   = sat32(sum_y);
    assign sat_one = sat32(sum_one);
    assign sat_two = sat32(sum_two);

    always_comb begin
        if (i_command == CMD_LOAD) begin
            o_y         = '0;
            o_state_one = i_load_one;
            o_state_two = i_load_two;
            o_sat       = 1'b0;
        end else begin
            o_y         = sat_y.val;
            o_state_one = sat_one.val;
            o_state_two = sat_two.val;
            o_sat       = sat_y.clip | sat_one.clip | sat_two.clip;
        end
    end

endmodule

[sv/state_space_step_two_state.sv]
// Two-state single-input single-output state-space model in fixed point. A step
// request (command 0) returns y = c1*x1 + c2*x2 from the state before the step and
// moves the state to x1' = a11*x1 + a12*x2 + b1*u, x2' = a21*x1 + a22*x2 + b2*u;
// a load request (command 1) writes both state values and returns y = 0. Every
// result carries the state after its request and a flag set when any sum clipped.
// Coefficients are signed Q3.28, samples and state signed Q15.16; products round
// half up and sums saturate to 32 bits. One request is taken per clock unless a
// full result register stalls; each passes the input register, then the result
// register. The state feedback is combinational through eight parallel 32x32
// multipliers, rounding, a three-input add and saturation. The user must write
// coefficients through the config port only while no request is in flight; the block does not enforce this.
`include "assert_macros.svh"

module state_space_step_two_state
    import ssst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_command,
    input  logic [DATA_W-1:0]    i_u_sample,
    input  logic [DATA_W-1:0]    i_load_one,
    input  logic [DATA_W-1:0]    i_load_two,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [DATA_W-1:0]    o_y_out,
    output logic [DATA_W-1:0]    o_state_one_out,
    output logic [DATA_W-1:0]    o_state_two_out,
    output logic                 o_saturated
);

    t_coefs            r_coefs;
    logic [DATA_W-1:0] r_state_one, r_state_two;
    logic              r_in_valid;
    logic              r_in_cmd;
    logic [DATA_W-1:0] r_in_u, r_in_load_one, r_in_load_two;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_y;
    logic              r_sat;

    logic              w_adv;
    logic [DATA_W-1:0] n_y, n_state_one, n_state_two;
    logic              n_sat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '{a11: RST_A11, a12: RST_A12, a21: RST_A21, a22: RST_A22,
                         b1: RST_B1, b2: RST_B2, c1: RST_C1, c2: RST_C2};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_A11: r_coefs.a11 <= i_cfg_data;
                REG_A12: r_coefs.a12 <= i_cfg_data;
                REG_A21: r_coefs.a21 <= i_cfg_data;
                REG_A22: r_coefs.a22 <= i_cfg_data;
                REG_B1:  r_coefs.b1  <= i_cfg_data;
                REG_B2:  r_coefs.b2  <= i_cfg_data;
                REG_C1:  r_coefs.c1  <= i_cfg_data;
                REG_C2:  r_coefs.c2  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the result register frees up whenever its contents are taken
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_cmd      <= i_command;
            r_in_u        <= i_u_sample;
            r_in_load_one <= i_load_one;
            r_in_load_two <= i_load_two;
        end
    end

    ssst_core u_core (
        .i_coefs     (r_coefs),
        .i_state_one (r_state_one),
        .i_state_two (r_state_two),
        .i_command   (r_in_cmd),
        .i_u_sample  (r_in_u),
        .i_load_one  (r_in_load_one),
        .i_load_two  (r_in_load_two),
        .o_y         (n_y),
        .o_state_one (n_state_one),
        .o_state_two (n_state_two),
        .o_sat       (n_sat)
    );

    // state changes only when a request moves into the result register, so it
    // always matches the state reported by a pending result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state_one <= '0;
            r_state_two <= '0;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_state_one <= n_state_one;
                r_state_two <= n_state_two;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_y   <= n_y;
            r_sat <= n_sat;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_y_out         = r_y;
    assign o_state_one_out = r_state_one;
    assign o_state_two_out = r_state_two;
    assign o_saturated     = r_sat;

    `ASSERT_IMPLY(a_load_result, i_clk, i_rst_n,
        (w_adv && r_in_cmd == CMD_LOAD) |=> (r_y == '0 && !r_sat))
    `ASSERT_IMPLY(a_state_hold, i_clk, i_rst_n,
        !w_adv |=> ($stable(r_state_one) && $stable(r_state_two)))
    `ASSERT_IMPLY(a_sat_extreme, i_clk, i_rst_n,
        (r_out_valid && r_sat) |-> (r_y == Q_MAX || r_y == Q_MIN
            || r_state_one == Q_MAX || r_state_one == Q_MIN
            || r_state_two == Q_MAX || r_state_two == Q_MIN))
    `ASSERT_NEVER(a_adv_blocked, i_clk, i_rst_n,
        w_adv && r_out_valid && !i_out_ready)

endmodule
